// ----- hdl/two_level_preemptive_scheduler_macros.svh -----
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shorthand for clocked assertions; clk and rst_n are taken from the module.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PREEMPTIVE_SCHEDULER_MACROS_SVH
`define TWO_LEVEL_PREEMPTIVE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define TPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// next-cycle implication
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ----- hdl/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants of the two-level preemptive scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int ID_FIELD_W = 16;  // width of id fields on the ports
  localparam int WIDE_W     = 32;  // staging width for id resizing

  typedef enum logic [1:0] {
    ACT_ARRIVE = 2'd0,
    ACT_SLICE  = 2'd1,
    ACT_TERM   = 2'd2,
    ACT_IO     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NORUN = 2'd2
  } status_t;

  typedef struct packed {
    action_t                 action;
    logic [ID_FIELD_W-1:0]   task_id;
    logic                    is_realtime;
  } event_t;

  typedef struct packed {
    logic                    running_valid;
    logic [ID_FIELD_W-1:0]   running_id;
    logic                    running_realtime;
    logic                    released_valid;
    logic [ID_FIELD_W-1:0]   released_id;
    status_t                 status;
  } result_t;

  // queue operations for one cycle
  typedef struct packed {
    logic enq_tail;
    logic enq_head;
    logic pop;
  } q_ctl_t;

endpackage

// ----- hdl/tps_in_if.sv -----
// ----------------------------------------------------------------------------
// tps_in_if
// Event request channel: valid/ready plus the event fields.
// ----------------------------------------------------------------------------
interface tps_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic [tps_pkg::ID_FIELD_W-1:0] task_id;
  logic                           is_realtime;

  modport source (output valid, output action, output task_id, output is_realtime,
                  input ready);
  modport sink   (input valid, input action, input task_id, input is_realtime,
                  output ready);
endinterface

// ----- hdl/tps_out_if.sv -----
// ----------------------------------------------------------------------------
// tps_out_if
// Result channel: valid/ready plus the scheduler state after each event.
// ----------------------------------------------------------------------------
interface tps_out_if;
  logic                           valid;
  logic                           ready;
  logic                           running_valid;
  logic [tps_pkg::ID_FIELD_W-1:0] running_id;
  logic                           running_realtime;
  logic                           released_valid;
  logic [tps_pkg::ID_FIELD_W-1:0] released_id;
  logic [1:0]                     status;

  modport source (output valid, output running_valid, output running_id,
                  output running_realtime, output released_valid,
                  output released_id, output status, input ready);
  modport sink   (input valid, input running_valid, input running_id,
                  input running_realtime, input released_valid,
                  input released_id, input status, output ready);
endinterface

// ----- hdl/tps_queue.sv -----
// ----------------------------------------------------------------------------
// tps_queue
// Circular task queue with push at either end, pop at the front, and a
// registered copy of the front entry.
// ----------------------------------------------------------------------------
module tps_queue #(
  parameter int DEPTH = 16,
  parameter int W     = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tps_pkg::q_ctl_t            ctl,
  input  logic [W-1:0]               wdata,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [W-1:0]               front
);
  import tps_pkg::*;

  `include "two_level_preemptive_scheduler_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [W-1:0]  front_r;

  logic [AW:0]   head_inc;
  logic [AW-1:0] head_p1, head_m1, tail, waddr;
  logic [CW:0]   tail_sum, tail_wrap;
  logic          we;

  always_comb begin
    head_inc  = {1'b0, head_r} + 1'b1;
    head_p1   = (head_inc == (AW+1)'(DEPTH)) ? '0 : head_inc[AW-1:0];
    head_m1   = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
    tail_sum  = (CW+1)'(head_r) + (CW+1)'(count_r);
    // head + count stays below twice the depth
    tail_wrap = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;
    tail      = tail_wrap[AW-1:0];
    we        = ctl.enq_tail | ctl.enq_head;
    waddr     = ctl.enq_head ? head_m1 : tail;

    if (ctl.pop) begin
      head_nxt = head_p1;
    end else if (ctl.enq_head) begin
      head_nxt = head_m1;
    end else begin
      head_nxt = head_r;
    end

    case ({we, ctl.pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // front entry for the next cycle, with write bypass
  always_ff @(posedge clk) begin
    if (we && (waddr == head_nxt)) begin
      front_r <= wdata;
    end else begin
      front_r <= mem[head_nxt];
    end
  end

  assign count = count_r;
  assign front = front_r;

  `TPS_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `TPS_ASSERT_IMPL(a_no_push_full, we, count_r != CW'(DEPTH))
  `TPS_ASSERT_IMPL(a_pop_nonempty, ctl.pop, (count_r != '0) || ctl.enq_tail)
  `TPS_ASSERT_IMPL(a_front_pop_excl, ctl.enq_head, !ctl.pop)

endmodule

// ----- hdl/tps_ctrl.sv -----
// ----------------------------------------------------------------------------
// tps_ctrl
// Event handling and dispatch for one request, plus the running slot.
// ----------------------------------------------------------------------------
module tps_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  tps_pkg::event_t                  ev,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] rt_count,
  input  logic [ID_BITS-1:0]               rt_front,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] cm_count,
  input  logic [ID_BITS-1:0]               cm_front,
  output tps_pkg::q_ctl_t                  rt_ctl,
  output logic [ID_BITS-1:0]               rt_wdata,
  output tps_pkg::q_ctl_t                  cm_ctl,
  output logic [ID_BITS-1:0]               cm_wdata,
  output tps_pkg::result_t                 res
);
  import tps_pkg::*;

  `include "two_level_preemptive_scheduler_macros.svh"

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic               run_v_r, run_v_nxt;
  logic [ID_BITS-1:0] run_id_r, run_id_nxt;
  logic               run_rt_r, run_rt_nxt;

  logic [WIDE_W-1:0]  in_ext, run_ext, rel_ext;
  logic [ID_BITS-1:0] in_id, rel_id, rt_top, cm_top;
  logic               rel_v;
  logic               rt_pb, cm_pb, cm_pf, rt_pop, cm_pop;
  logic [ID_BITS-1:0] ev_cm_wd;
  logic [CW-1:0]      rt_cnt1, cm_cnt1;
  logic               run_v1, run_rt1;
  logic [ID_BITS-1:0] run_id1;
  status_t            status;

  always_comb begin
    in_ext   = WIDE_W'(ev.task_id);
    in_id    = in_ext[ID_BITS-1:0];
    status   = ST_OK;
    rel_v    = 1'b0;
    rel_id   = '0;
    rt_pb    = 1'b0;
    cm_pb    = 1'b0;
    cm_pf    = 1'b0;
    rt_pop   = 1'b0;
    cm_pop   = 1'b0;
    rt_wdata = in_id;
    ev_cm_wd = in_id;
    run_v1   = run_v_r;
    run_id1  = run_id_r;
    run_rt1  = run_rt_r;

    // event
    case (ev.action)
      ACT_ARRIVE: begin
        if (ev.is_realtime) begin
          if (rt_count != FULL_CNT) rt_pb = 1'b1;
          else status = ST_FULL;
        end else begin
          if (cm_count != FULL_CNT) cm_pb = 1'b1;
          else status = ST_FULL;
        end
      end
      ACT_SLICE: begin
        if (!run_v_r) begin
          status = ST_NORUN;
        end else if (run_rt_r) begin
          rt_wdata = run_id_r;
          if (rt_count != FULL_CNT) begin
            rt_pb  = 1'b1;
            run_v1 = 1'b0;
          end else begin
            status = ST_FULL;
          end
        end else begin
          ev_cm_wd = run_id_r;
          if (cm_count != FULL_CNT) begin
            cm_pb  = 1'b1;
            run_v1 = 1'b0;
          end else begin
            status = ST_FULL;
          end
        end
      end
      default: begin
        if (!run_v_r) begin
          status = ST_NORUN;
        end else begin
          rel_v  = 1'b1;
          rel_id = run_id_r;
          run_v1 = 1'b0;
        end
      end
    endcase

    // queue view after the event; a push into an empty queue is its front
    rt_cnt1 = rt_count + CW'(rt_pb);
    cm_cnt1 = cm_count + CW'(cm_pb);
    rt_top  = (rt_count == '0) ? rt_wdata : rt_front;
    cm_top  = (cm_count == '0) ? ev_cm_wd : cm_front;

    run_v_nxt  = run_v1;
    run_id_nxt = run_id1;
    run_rt_nxt = run_rt1;

    // dispatch
    if (!run_v1 && (rt_cnt1 != '0)) begin
      rt_pop     = 1'b1;
      run_v_nxt  = 1'b1;
      run_id_nxt = rt_top;
      run_rt_nxt = 1'b1;
    end else if (run_v1 && (rt_cnt1 != '0)) begin
      if (!run_rt1) begin
        if (cm_cnt1 == FULL_CNT) begin
          status = ST_FULL;
        end else begin
          // preempted common task goes back to the front
          cm_pf      = 1'b1;
          rt_pop     = 1'b1;
          run_id_nxt = rt_top;
          run_rt_nxt = 1'b1;
        end
      end
    end else if (!run_v1 && (cm_cnt1 != '0)) begin
      cm_pop     = 1'b1;
      run_v_nxt  = 1'b1;
      run_id_nxt = cm_top;
      run_rt_nxt = 1'b0;
    end

    cm_wdata = cm_pf ? run_id1 : ev_cm_wd;

    rt_ctl.enq_tail = en & rt_pb;
    rt_ctl.enq_head = 1'b0;
    rt_ctl.pop      = en & rt_pop;
    cm_ctl.enq_tail = en & cm_pb;
    cm_ctl.enq_head = en & cm_pf;
    cm_ctl.pop      = en & cm_pop;

    run_ext              = WIDE_W'(run_id_nxt);
    rel_ext              = WIDE_W'(rel_id);
    res.running_valid    = run_v_nxt;
    res.running_id       = run_v_nxt ? run_ext[ID_FIELD_W-1:0] : '0;
    res.running_realtime = run_v_nxt & run_rt_nxt;
    res.released_valid   = rel_v;
    res.released_id      = rel_ext[ID_FIELD_W-1:0];
    res.status           = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_v_r  <= 1'b0;
      run_rt_r <= 1'b0;
      run_id_r <= '0;
    end else if (en) begin
      run_v_r  <= run_v_nxt;
      run_rt_r <= run_rt_nxt;
      run_id_r <= run_id_nxt;
    end
  end

  `TPS_ASSERT_NEXT(a_rt_not_preempted,
                   en && run_v_r && run_rt_r && (ev.action == ACT_ARRIVE),
                   run_v_r && run_rt_r)
  `TPS_ASSERT_IMPL(a_release_needs_run, en && res.released_valid, run_v_r)
  `TPS_ASSERT_IMPL(a_cm_single_write, 1'b1, !(cm_ctl.enq_tail && cm_ctl.enq_head))

endmodule

// ----- hdl/two_level_preemptive_scheduler.sv -----
// ----------------------------------------------------------------------------
// two_level_preemptive_scheduler
// Real-time FIFO, common deque and running slot for one processor.
// ----------------------------------------------------------------------------
// Takes one event request per cycle and returns one result per event: the
// event is held in an input register, the whole event-plus-dispatch decision
// is made in combinational logic, and the result lands in an output register.
// Throughput is one event per clock, set by that single decision stage and
// the one-write-per-cycle queue memories; it drops only while the result
// channel stalls. Queue entries are not cleared at reset and need no clearing
// pass; the block is ready right after reset.
module two_level_preemptive_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tps_in_if.sink     in_req,
  tps_out_if.source  out_res
);
  import tps_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic     ev_v_r;
  event_t   ev_r;
  logic     res_v_r;
  result_t  res_r;
  logic     en;

  q_ctl_t             rt_ctl, cm_ctl;
  logic [ID_BITS-1:0] rt_wdata, cm_wdata, rt_front, cm_front;
  logic [CW-1:0]      rt_count, cm_count;
  result_t            res_nxt;

  assign en           = ev_v_r & (~res_v_r | out_res.ready);
  assign in_req.ready = ~ev_v_r | en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      if (in_req.ready) begin
        ev_v_r <= in_req.valid;
      end
      if (en) begin
        res_v_r <= 1'b1;
      end else if (out_res.ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.ready && in_req.valid) begin
      ev_r.action      <= action_t'(in_req.action);
      ev_r.task_id     <= in_req.task_id;
      ev_r.is_realtime <= in_req.is_realtime;
    end
    if (en) begin
      res_r <= res_nxt;
    end
  end

  tps_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ev       (ev_r),
    .rt_count (rt_count),
    .rt_front (rt_front),
    .cm_count (cm_count),
    .cm_front (cm_front),
    .rt_ctl   (rt_ctl),
    .rt_wdata (rt_wdata),
    .cm_ctl   (cm_ctl),
    .cm_wdata (cm_wdata),
    .res      (res_nxt)
  );

  tps_queue #(.DEPTH(QUEUE_DEPTH), .W(ID_BITS)) u_rt_q (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rt_ctl),
    .wdata (rt_wdata),
    .count (rt_count),
    .front (rt_front)
  );

  tps_queue #(.DEPTH(QUEUE_DEPTH), .W(ID_BITS)) u_cm_q (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cm_ctl),
    .wdata (cm_wdata),
    .count (cm_count),
    .front (cm_front)
  );

  assign out_res.valid            = res_v_r;
  assign out_res.running_valid    = res_r.running_valid;
  assign out_res.running_id       = res_r.running_id;
  assign out_res.running_realtime = res_r.running_realtime;
  assign out_res.released_valid   = res_r.released_valid;
  assign out_res.released_id      = res_r.released_id;
  assign out_res.status           = res_r.status;

endmodule
